### rtl/core/hcr_pkg.sv
// Package for the hard collision response unit: shared types, constants and helpers.
// Has no dependencies; the top level and the front, divider and back pipelines import it.
`default_nettype none
package hcr_pkg;

  localparam int ONE_Q16 = 65536;
  localparam int QW = 36;
  localparam int DVD_W = 62;
  localparam int QQ_W = 30;
  localparam int QM_W = 14;
  localparam logic [4:0] NORM_EXP = 5'd13;

  localparam logic [1:0] OUT_NONE = 2'd0;
  localparam logic [1:0] OUT_STUCK = 2'd1;
  localparam logic [1:0] OUT_REFLECT = 2'd2;
  localparam logic [1:0] OUT_UNUSED = 2'd3;

  localparam logic [1:0] REG_ELASTICITY = 2'd0;
  localparam logic [1:0] REG_DAMPING = 2'd1;
  localparam logic [1:0] REG_HALTING = 2'd2;

  typedef logic [2:0][31:0] vec32_t;
  typedef logic [2:0][32:0] vec33_t;

  typedef struct packed {
    vec32_t pos;
    vec32_t vel;
    vec32_t sv;
    vec33_t r;
    logic [1:0] outcome;
  } side_t;

  typedef struct packed {
    logic [2:0][QQ_W-1:0] rem;
    logic [2:0][QW-1:0] low;
    logic [2:0][QW-1:0] quo;
    logic [2:0] neg;
    logic [QQ_W-1:0] qq;
    side_t side;
  } div_t;

  function automatic logic [31:0] sat33(input logic [32:0] v);
    logic [31:0] res;
    if (v[32] != v[31]) begin
      res = v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  function automatic logic [31:0] sat42(input logic [41:0] v);
    logic [31:0] res;
    if ((v[41:31] == '0) || (v[41:31] == '1)) begin
      res = v[31:0];
    end else begin
      res = v[41] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    return res;
  endfunction

  function automatic logic [4:0] msb_pos(input logic [31:0] v);
    logic [4:0] p;
    p = '0;
    for (int k = 0; k < 32; k++) begin
      if (v[k]) p = 5'(k);
    end
    return p;
  endfunction

endpackage
`default_nettype wire

### rtl/core/hcr_if.sv
// Channel interfaces of the hard collision response unit: contact input, result, register write.
// Has no dependencies; the register index is a plain two-bit field.
`default_nettype none
interface hcr_in_if;
  logic valid;
  logic ready;
  logic [31:0] pos_x, pos_y, pos_z;
  logic [31:0] vel_x, vel_y, vel_z;
  logic [31:0] surf_vel_x, surf_vel_y, surf_vel_z;
  logic [31:0] pen_x, pen_y, pen_z;
  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  surf_vel_x, surf_vel_y, surf_vel_z, pen_x, pen_y, pen_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                surf_vel_x, surf_vel_y, surf_vel_z, pen_x, pen_y, pen_z, output ready);
endinterface

interface hcr_out_if;
  logic valid;
  logic ready;
  logic [31:0] new_pos_x, new_pos_y, new_pos_z;
  logic [31:0] new_vel_x, new_vel_y, new_vel_z;
  logic [1:0] outcome;
  modport source (output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                  new_vel_z, outcome, input ready);
  modport sink (input valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                new_vel_z, outcome, output ready);
endinterface

interface hcr_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/core/hard_collision_response_unit.sv
// Top level of the hard collision response unit: channels, registers and pipeline control.
// Uses hcr_pkg, the interfaces in hcr_if and the hcr_front, hcr_div and hcr_back pipelines.
//
//   channel  | direction | handshake     | carries
//   in_ch    | sink      | valid / ready | position, velocity, surface velocity, penetration
//   out_ch   | source    | valid / ready | resolved position, velocity, outcome
//   cfg      | sink      | valid / ready | register index, write data
//
// A request can enter every cycle while the output is not stalled.
// The divider has 36 stages, one quotient bit per stage.
// Reset clears all valid bits and loads the default register values.
// A stalled output freezes the whole pipeline, which then also stalls the input.
// Register writes are always accepted.
`default_nettype none
module hard_collision_response_unit import hcr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input logic clk,
  input logic rst,
  hcr_in_if.sink in_ch,
  hcr_out_if.source out_ch,
  hcr_cfg_if.sink cfg
);

  localparam logic [63:0] HaltReset64 = ((64'd16366 << FRAC_BITS) + 64'd50000) / 64'd100000;

  logic [16:0] elasticity, damping;
  logic [30:0] halting_speed;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      elasticity <= 17'd26214;
      damping <= 17'd3277;
      halting_speed <= HaltReset64[30:0];
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_ELASTICITY: elasticity <= cfg.data[16:0];
        REG_DAMPING:    damping <= cfg.data[16:0];
        REG_HALTING:    halting_speed <= cfg.data[30:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  vec32_t pos, vel, sv, pen;
  assign pos = {in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};
  assign vel = {in_ch.vel_z, in_ch.vel_y, in_ch.vel_x};
  assign sv = {in_ch.surf_vel_z, in_ch.surf_vel_y, in_ch.surf_vel_x};
  assign pen = {in_ch.pen_z, in_ch.pen_y, in_ch.pen_x};

  logic f_valid, d_valid;
  logic [2:0][DVD_W-1:0] dvd;
  logic [2:0] neg, quo_neg;
  logic [QQ_W-1:0] qq;
  side_t f_side, d_side;
  logic [2:0][QW-1:0] quo;
  vec32_t new_pos, new_vel;

  hcr_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_ch.valid),
    .pos(pos), .vel(vel), .sv(sv), .pen(pen), .halting_speed(halting_speed),
    .out_valid(f_valid), .dvd(dvd), .neg(neg), .qq_out(qq), .side_out(f_side)
  );

  hcr_div u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(f_valid),
    .dvd(dvd), .neg(neg), .qq(qq), .side_in(f_side),
    .out_valid(d_valid), .quo(quo), .quo_neg(quo_neg), .side_out(d_side)
  );

  hcr_back u_back (
    .clk(clk), .rst(rst), .en(en), .in_valid(d_valid),
    .quo(quo), .quo_neg(quo_neg), .side_in(d_side),
    .elasticity(elasticity), .damping(damping),
    .out_valid(out_ch.valid), .new_pos(new_pos), .new_vel(new_vel),
    .outcome(out_ch.outcome)
  );

  assign out_ch.new_pos_x = new_pos[0];
  assign out_ch.new_pos_y = new_pos[1];
  assign out_ch.new_pos_z = new_pos[2];
  assign out_ch.new_vel_x = new_vel[0];
  assign out_ch.new_vel_y = new_vel[1];
  assign out_ch.new_vel_z = new_vel[2];

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_ch.valid)
    else $error("Result valid right after reset.");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
      !en |=> $stable(f_valid) && $stable(d_valid))
    else $error("Pipeline moved while the output was stalled.");

  a_outcome_code: assert property (@(posedge clk) disable iff (rst)
      out_ch.valid |-> out_ch.outcome != OUT_UNUSED)
    else $error("Result carries an unused outcome code.");

endmodule
`default_nettype wire

### rtl/core/hcr_front.sv
// Front pipeline: relative velocity, contact and halting tests, penetration normalization,
// and the per-axis dividends and common divisor for the projection. Uses hcr_pkg.
`default_nettype none
module hcr_front import hcr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  vec32_t pos,
  input  vec32_t vel,
  input  vec32_t sv,
  input  vec32_t pen,
  input  logic [30:0] halting_speed,
  output logic out_valid,
  output logic [2:0][DVD_W-1:0] dvd,
  output logic [2:0] neg,
  output logic [QQ_W-1:0] qq_out,
  output side_t side_out
);

  logic a_v, b_v, c_v, d_v, e_v, f_v;
  vec33_t a_r, a_rm, a_r_next, a_rm_next;
  vec32_t a_pp, a_pm, a_pos, a_vel, a_sv, a_pen;
  vec32_t a_pp_next, a_pm_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_r_next[i] = {sv[i][31], sv[i]} - {vel[i][31], vel[i]};
      a_pp_next[i] = sat33({pos[i][31], pos[i]} - {pen[i][31], pen[i]});
      a_pm_next[i] = pen[i][31] ? 32'(-pen[i]) : pen[i];
      a_rm_next[i] = a_r_next[i][32] ? 33'(-a_r_next[i]) : a_r_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= in_valid;
    end
    if (en) begin
      a_r <= a_r_next;
      a_rm <= a_rm_next;
      a_pp <= a_pp_next;
      a_pm <= a_pm_next;
      a_pos <= pos;
      a_vel <= vel;
      a_sv <= sv;
      a_pen <= pen;
    end
  end

  logic [2:0][64:0] b_dp, b_dp_next;
  logic [2:0][61:0] b_sq, b_sq_next;
  logic b_big, b_big_next;
  logic [61:0] b_hs2;
  logic [31:0] b_mx, b_mx_next;
  logic [2:0] b_pneg;
  vec32_t b_pm, b_pp, b_pos, b_vel, b_sv;
  vec33_t b_r;
  logic signed [64:0] ra, pa;

  always_comb begin
    b_big_next = 1'b0;
    for (int i = 0; i < 3; i++) begin
      ra = 65'(signed'(a_r[i]));
      pa = 65'(signed'(a_pen[i]));
      b_dp_next[i] = ra * pa;
      b_sq_next[i] = 62'(a_rm[i][30:0]) * 62'(a_rm[i][30:0]);
      b_big_next = b_big_next | (|a_rm[i][32:31]);
    end
    b_mx_next = a_pm[0];
    if (a_pm[1] > b_mx_next) b_mx_next = a_pm[1];
    if (a_pm[2] > b_mx_next) b_mx_next = a_pm[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= a_v;
    end
    if (en) begin
      b_dp <= b_dp_next;
      b_sq <= b_sq_next;
      b_big <= b_big_next;
      b_hs2 <= 62'(halting_speed) * 62'(halting_speed);
      b_mx <= b_mx_next;
      for (int i = 0; i < 3; i++) b_pneg[i] <= a_pen[i][31];
      b_pm <= a_pm;
      b_pp <= a_pp;
      b_pos <= a_pos;
      b_vel <= a_vel;
      b_sv <= a_sv;
      b_r <= a_r;
    end
  end

  logic [66:0] dot;
  logic [63:0] sqs;
  logic contact, slow;
  side_t c_side, c_side_next;
  logic [4:0] c_lead;
  vec32_t c_pm;
  logic [2:0] c_pneg;

  always_comb begin
    dot = 67'(signed'(b_dp[0])) + 67'(signed'(b_dp[1])) + 67'(signed'(b_dp[2]));
    sqs = 64'(b_sq[0]) + 64'(b_sq[1]) + 64'(b_sq[2]);
    contact = dot[66];
    slow = (b_hs2 != '0) && !b_big && (sqs < 64'(b_hs2));
    c_side_next.pos = contact ? b_pp : b_pos;
    c_side_next.vel = b_vel;
    c_side_next.sv = b_sv;
    c_side_next.r = b_r;
    if (!contact) begin
      c_side_next.outcome = OUT_NONE;
    end else if (slow) begin
      c_side_next.outcome = OUT_STUCK;
    end else begin
      c_side_next.outcome = OUT_REFLECT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= b_v;
    end
    if (en) begin
      c_side <= c_side_next;
      c_lead <= msb_pos(b_mx);
      c_pm <= b_pm;
      c_pneg <= b_pneg;
    end
  end

  logic [2:0][QM_W-1:0] d_qm, d_qm_next;
  logic [2:0] d_pneg;
  side_t d_side;
  logic [31:0] sh;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (c_lead >= NORM_EXP) begin
        sh = c_pm[i] >> (c_lead - NORM_EXP);
      end else begin
        sh = c_pm[i] << (NORM_EXP - c_lead);
      end
      d_qm_next[i] = sh[QM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (en) begin
      d_v <= c_v;
    end
    if (en) begin
      d_qm <= d_qm_next;
      d_pneg <= c_pneg;
      d_side <= c_side;
    end
  end

  logic [2:0][47:0] e_rq, e_rq_next;
  logic [2:0][27:0] e_qq;
  logic [2:0][QM_W-1:0] e_qm;
  logic [2:0] e_pneg;
  side_t e_side;
  logic [QM_W:0] qs;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs = d_pneg[i] ? (QM_W + 1)'(-{1'b0, d_qm[i]}) : {1'b0, d_qm[i]};
      e_rq_next[i] = 48'(signed'(d_side.r[i])) * 48'(signed'(qs));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (en) begin
      e_v <= d_v;
    end
    if (en) begin
      e_rq <= e_rq_next;
      for (int i = 0; i < 3; i++) e_qq[i] <= 28'(d_qm[i]) * 28'(d_qm[i]);
      e_qm <= d_qm;
      e_pneg <= d_pneg;
      e_side <= d_side;
    end
  end

  logic [49:0] rq_sum;
  logic f_rqneg;
  logic [48:0] f_rqmag;
  logic [QQ_W-1:0] f_qq;
  logic [2:0][QM_W-1:0] f_qm;
  logic [2:0] f_pneg;
  side_t f_side;

  assign rq_sum = 50'(signed'(e_rq[0])) + 50'(signed'(e_rq[1])) + 50'(signed'(e_rq[2]));

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (en) begin
      f_v <= e_v;
    end
    if (en) begin
      f_rqneg <= rq_sum[49];
      f_rqmag <= rq_sum[49] ? 49'(-rq_sum) : rq_sum[48:0];
      f_qq <= QQ_W'(e_qq[0]) + QQ_W'(e_qq[1]) + QQ_W'(e_qq[2]);
      f_qm <= e_qm;
      f_pneg <= e_pneg;
      f_side <= e_side;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= f_v;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dvd[i] <= DVD_W'(63'(f_qm[i]) * 63'(f_rqmag));
        neg[i] <= f_pneg[i] ^ f_rqneg;
      end
      qq_out <= f_qq;
      side_out <= f_side;
    end
  end

endmodule
`default_nettype wire

### rtl/core/hcr_div.sv
// Restoring divider, one quotient bit per stage for all three axes, sharing one divisor.
// Uses hcr_pkg for the stage record and widths.
`default_nettype none
module hcr_div import hcr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [2:0][DVD_W-1:0] dvd,
  input  logic [2:0] neg,
  input  logic [QQ_W-1:0] qq,
  input  side_t side_in,
  output logic out_valid,
  output logic [2:0][QW-1:0] quo,
  output logic [2:0] quo_neg,
  output side_t side_out
);

  function automatic div_t div_step(input div_t x);
    div_t y;
    logic [QQ_W:0] t;
    y = x;
    for (int i = 0; i < 3; i++) begin
      t = {x.rem[i], x.low[i][QW-1]};
      if (t >= {1'b0, x.qq}) begin
        y.rem[i] = QQ_W'(t - {1'b0, x.qq});
        y.quo[i] = {x.quo[i][QW-2:0], 1'b1};
      end else begin
        y.rem[i] = t[QQ_W-1:0];
        y.quo[i] = {x.quo[i][QW-2:0], 1'b0};
      end
      y.low[i] = {x.low[i][QW-2:0], 1'b0};
    end
    return y;
  endfunction

  div_t start;
  div_t stg [QW];
  logic vld [QW];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      start.rem[i] = QQ_W'(dvd[i][DVD_W-1:QW]);
      start.low[i] = dvd[i][QW-1:0];
      start.quo[i] = '0;
    end
    start.neg = neg;
    start.qq = qq;
    start.side = side_in;
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= (k == 0) ? in_valid : vld[(k == 0) ? 0 : k - 1];
      end
      if (en) begin
        stg[k] <= div_step((k == 0) ? start : stg[(k == 0) ? 0 : k - 1]);
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign quo = stg[QW-1].quo;
  assign quo_neg = stg[QW-1].neg;
  assign side_out = stg[QW-1].side;

endmodule
`default_nettype wire

### rtl/core/hcr_back.sv
// Back pipeline: signed projection, restitution and damping gains, rescale and saturation,
// and the output register. Uses hcr_pkg.
`default_nettype none
module hcr_back import hcr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [2:0][QW-1:0] quo,
  input  logic [2:0] quo_neg,
  input  side_t side_in,
  input  logic [16:0] elasticity,
  input  logic [16:0] damping,
  output logic out_valid,
  output vec32_t new_pos,
  output vec32_t new_vel,
  output logic [1:0] outcome
);

  logic [17:0] gain;
  logic [16:0] dcl;

  assign gain = 18'(ONE_Q16) + 18'(elasticity);
  assign dcl = (damping > 17'(ONE_Q16)) ? 17'(ONE_Q16) : damping;

  logic h_v, i_v, j_v;
  logic [2:0][QW:0] h_n, h_n_next;
  logic [2:0][QW+1:0] h_rn, h_rn_next;
  side_t h_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      h_n_next[i] = quo_neg[i] ? (QW + 1)'(-{1'b0, quo[i]}) : {1'b0, quo[i]};
      h_rn_next[i] = (QW + 2)'(signed'(side_in.r[i])) - (QW + 2)'(signed'(h_n_next[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_v <= 1'b0;
    end else if (en) begin
      h_v <= in_valid;
    end
    if (en) begin
      h_n <= h_n_next;
      h_rn <= h_rn_next;
      h_side <= side_in;
    end
  end

  logic [2:0][55:0] i_a, i_b;
  side_t i_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      i_v <= 1'b0;
    end else if (en) begin
      i_v <= h_v;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        i_a[i] <= 56'(signed'({1'b0, gain})) * 56'(signed'(h_n[i]));
        i_b[i] <= 56'(signed'({1'b0, dcl})) * 56'(signed'(h_rn[i]));
      end
      i_side <= h_side;
    end
  end

  logic signed [56:0] s, s2;
  logic [2:0][40:0] j_t, j_t_next;
  side_t j_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s = 57'(signed'(i_a[i])) + 57'(signed'(i_b[i]));
      s2 = s + (s[56] ? 57'(ONE_Q16 - 1) : 57'(0));
      j_t_next[i] = s2[56:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j_v <= 1'b0;
    end else if (en) begin
      j_v <= i_v;
    end
    if (en) begin
      j_t <= j_t_next;
      j_side <= i_side;
    end
  end

  vec32_t vel_next;
  logic [41:0] vsum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vsum = 42'(signed'(j_side.vel[i])) + 42'(signed'(j_t[i]));
      unique case (j_side.outcome)
        OUT_REFLECT: vel_next[i] = sat42(vsum);
        OUT_STUCK:   vel_next[i] = j_side.sv[i];
        default:     vel_next[i] = j_side.vel[i];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= j_v;
    end
    if (en) begin
      new_pos <= j_side.pos;
      new_vel <= vel_next;
      outcome <= j_side.outcome;
    end
  end

endmodule
`default_nettype wire
